// File: hdl/ets_pkg.sv
// Package for the epoch seconds to UTC date converter: widths, constants, month table.
package ets_pkg;

  localparam int SECONDS_WIDTH = 36;
  // Non-negative magnitude bits of the input
  localparam int MAG_W   = SECONDS_WIDTH - 1;
  // 86400 > 2^16, so the day count needs at most MAG_W-16 bits
  localparam int DAYS_W  = MAG_W - 16;
  // Operand width of the shared compare/subtract unit: remaining seconds
  localparam int UW      = MAG_W;
  // Years since 1900: days/365 plus the 1970 offset
  localparam int YEAR_W  = (DAYS_W - 7 > 11) ? DAYS_W - 7 : 11;

  localparam logic [UW-1:0]     SECS_MIN   = UW'(60);
  localparam logic [UW-1:0]     SECS_HOUR  = UW'(3600);
  localparam logic [UW-1:0]     SECS_DAY   = UW'(86400);
  localparam logic [UW-1:0]     SECS_YEAR  = UW'(365 * 86400);
  localparam logic [UW-1:0]     SECS_LEAP  = UW'(366 * 86400);
  localparam logic [2:0]        EPOCH_WDAY = 3'd4;   // 1970-01-01 was a Thursday
  localparam logic [3:0]        MON_DEC    = 4'd11;

  // 1970 relative to 1900 and its residues for the leap rule
  localparam logic [YEAR_W-1:0] EPOCH_YEAR = YEAR_W'(70);
  localparam logic [1:0]        EPOCH_M4   = 2'd2;
  localparam logic [6:0]        EPOCH_M100 = 7'd70;
  localparam logic [8:0]        EPOCH_M400 = 9'd370;
  localparam logic [6:0]        M100_LAST  = 7'd99;
  localparam logic [8:0]        M400_LAST  = 9'd399;

  typedef struct packed {
    logic          ge;
    logic [UW-1:0] diff;
  } cs_res_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [UW-1:0] month_secs(input logic [4:0] len);
    logic [UW-1:0] secs;
    case (len)
      5'd28:   secs = UW'(28 * 86400);
      5'd29:   secs = UW'(29 * 86400);
      5'd30:   secs = UW'(30 * 86400);
      default: secs = UW'(31 * 86400);
    endcase
    return secs;
  endfunction

  // Weekday advanced by step days, step below 7
  function automatic logic [2:0] wday_add(input logic [2:0] w, input logic [2:0] step);
    logic [3:0] sum;
    sum = {1'b0, w} + {1'b0, step};
    return (sum >= 4'd7) ? 3'(sum - 4'd7) : sum[2:0];
  endfunction

endpackage

// File: hdl/ets_cmp_sub.sv
// Shared compare-and-subtract unit used by every step of the converter.
module ets_cmp_sub
  import ets_pkg::*;
(
  input  logic [UW-1:0] a_i,
  input  logic [UW-1:0] b_i,
  output cs_res_t       res_o
);

  logic [UW:0] diff;

  assign diff       = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~diff[UW];
  assign res_o.diff = diff[UW-1:0];

endmodule

// File: hdl/epoch_seconds_to_utc_date.sv
// Top level: epoch seconds to UTC calendar date, sequenced over one compare/subtract unit.
//
// Converts a signed count of seconds since 1970-01-01 UTC into the broken-down UTC
// date and time. One item is worked at a time; in_stall_o stays high from acceptance
// until the result is loaded into the output register, which can still be waiting on
// out_stall_i while the next item runs. The count is taken apart by the single
// compare/subtract unit, one step per cycle: whole years of seconds (365 or 366 days)
// until less than a year is left, then months, days, hours and minutes the same way;
// what remains is the second. Weekday and day of year are counted alongside. Each
// stage takes off one unit per step and moves on at the first step that finds less
// than a unit left (months also at December); the result is then loaded into the
// result register once the output register is free or being read. The next item is
// taken after the load has returned the sequencer to idle. A negative item skips the
// arithmetic and goes straight to the load; its result, valid_res_o = 0 with all
// fields zero, is loaded as soon as the output register is free or being read.
module epoch_seconds_to_utc_date
  import ets_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [SECONDS_WIDTH-1:0] epoch_seconds_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            valid_res_o,
  output logic [5:0]                      second_of_minute_o,
  output logic [5:0]                      minute_of_hour_o,
  output logic [4:0]                      hour_of_day_o,
  output logic [2:0]                      day_of_week_o,
  output logic [8:0]                      day_of_year_o,
  output logic [3:0]                      month_index_o,
  output logic [4:0]                      day_of_month_o,
  output logic [10:0]                     years_since_1900_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_YEAR = 3'd1;
  localparam logic [2:0] S_MON  = 3'd2;
  localparam logic [2:0] S_DAY  = 3'd3;
  localparam logic [2:0] S_HOUR = 3'd4;
  localparam logic [2:0] S_MIN  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state_q, state_d;
  logic              neg_q, neg_d;
  logic [UW-1:0]     rem_q, rem_d;
  logic [5:0]        min_q, min_d;
  logic [4:0]        hour_q, hour_d;
  logic [4:0]        mday_q, mday_d;
  logic [2:0]        wday_q, wday_d;
  logic [8:0]        yday_q, yday_d;
  logic [3:0]        mon_q, mon_d;
  logic [YEAR_W-1:0] year_q, year_d;
  logic [1:0]        m4_q, m4_d;
  logic [6:0]        m100_q, m100_d;
  logic [8:0]        m400_q, m400_d;

  logic              out_valid_q, out_valid_d;
  logic              res_ok_q;
  logic [5:0]        res_sec_q;
  logic [5:0]        res_min_q;
  logic [4:0]        res_hour_q;
  logic [2:0]        res_wday_q;
  logic [8:0]        res_yday_q;
  logic [3:0]        res_mon_q;
  logic [4:0]        res_mday_q;
  logic [10:0]       res_year_q;

  logic              in_acc;
  logic              out_load;
  logic              leap;
  logic [4:0]        mlen;
  logic [UW-1:0]     op_b;
  cs_res_t           cs;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign leap = (m4_q == 2'd0) && ((m100_q != 7'd0) || (m400_q == 9'd0));
  assign mlen = month_len(mon_q, leap);

  always_comb begin
    case (state_q)
      S_YEAR:  op_b = leap ? SECS_LEAP : SECS_YEAR;
      S_MON:   op_b = month_secs(mlen);
      S_DAY:   op_b = SECS_DAY;
      S_HOUR:  op_b = SECS_HOUR;
      S_MIN:   op_b = SECS_MIN;
      default: op_b = SECS_MIN;
    endcase
  end

  ets_cmp_sub u_cmp_sub (
    .a_i   (rem_q),
    .b_i   (op_b),
    .res_o (cs)
  );

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    rem_d   = rem_q;
    min_d   = min_q;
    hour_d  = hour_q;
    mday_d  = mday_q;
    wday_d  = wday_q;
    yday_d  = yday_q;
    mon_d   = mon_q;
    year_d  = year_q;
    m4_d    = m4_q;
    m100_d  = m100_q;
    m400_d  = m400_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          neg_d   = epoch_seconds_i[SECONDS_WIDTH-1];
          rem_d   = epoch_seconds_i[MAG_W-1:0];
          min_d   = '0;
          hour_d  = '0;
          mday_d  = '0;
          wday_d  = EPOCH_WDAY;
          yday_d  = '0;
          mon_d   = '0;
          year_d  = EPOCH_YEAR;
          m4_d    = EPOCH_M4;
          m100_d  = EPOCH_M100;
          m400_d  = EPOCH_M400;
          state_d = epoch_seconds_i[SECONDS_WIDTH-1] ? S_DONE : S_YEAR;
        end
      end
      S_YEAR: begin
        if (cs.ge) begin
          rem_d  = cs.diff;
          year_d = year_q + YEAR_W'(1);
          m4_d   = m4_q + 2'd1;
          m100_d = (m100_q == M100_LAST) ? 7'd0 : m100_q + 7'd1;
          m400_d = (m400_q == M400_LAST) ? 9'd0 : m400_q + 9'd1;
          // 365 and 366 days move the weekday by one and two
          wday_d = wday_add(wday_q, leap ? 3'd2 : 3'd1);
        end else begin
          state_d = S_MON;
        end
      end
      S_MON: begin
        if (cs.ge && (mon_q != MON_DEC)) begin
          rem_d  = cs.diff;
          mon_d  = mon_q + 4'd1;
          yday_d = yday_q + {4'd0, mlen};
          // month length mod 7 is its length minus 28
          wday_d = wday_add(wday_q, 3'(mlen - 5'd28));
        end else begin
          state_d = S_DAY;
        end
      end
      S_DAY: begin
        if (cs.ge) begin
          rem_d  = cs.diff;
          mday_d = mday_q + 5'd1;
          yday_d = yday_q + 9'd1;
          wday_d = wday_add(wday_q, 3'd1);
        end else begin
          state_d = S_HOUR;
        end
      end
      S_HOUR: begin
        if (cs.ge) begin
          rem_d  = cs.diff;
          hour_d = hour_q + 5'd1;
        end else begin
          state_d = S_MIN;
        end
      end
      S_MIN: begin
        if (cs.ge) begin
          rem_d = cs.diff;
          min_d = min_q + 6'd1;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    rem_q  <= rem_d;
    min_q  <= min_d;
    hour_q <= hour_d;
    mday_q <= mday_d;
    wday_q <= wday_d;
    yday_q <= yday_d;
    mon_q  <= mon_d;
    year_q <= year_d;
    m4_q   <= m4_d;
    m100_q <= m100_d;
    m400_q <= m400_d;
    if (out_load) begin
      res_ok_q   <= !neg_q;
      res_sec_q  <= neg_q ? 6'd0 : rem_q[5:0];
      res_min_q  <= neg_q ? 6'd0 : min_q;
      res_hour_q <= neg_q ? 5'd0 : hour_q;
      res_wday_q <= neg_q ? 3'd0 : wday_q;
      res_yday_q <= neg_q ? 9'd0 : yday_q;
      res_mon_q  <= neg_q ? 4'd0 : mon_q;
      res_mday_q <= neg_q ? 5'd0 : mday_q + 5'd1;
      res_year_q <= neg_q ? 11'd0 : year_q[10:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign valid_res_o        = res_ok_q;
  assign second_of_minute_o = res_sec_q;
  assign minute_of_hour_o   = res_min_q;
  assign hour_of_day_o      = res_hour_q;
  assign day_of_week_o      = res_wday_q;
  assign day_of_year_o      = res_yday_q;
  assign month_index_o      = res_mon_q;
  assign day_of_month_o     = res_mday_q;
  assign years_since_1900_o = res_year_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("converter not busy after taking an item");

  a_month_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MON) |-> (rem_q < SECS_LEAP))
    else $error("seconds left exceed a year in month walk");

  a_min_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MIN) |-> (rem_q < SECS_HOUR))
    else $error("seconds left exceed an hour in minute walk");

  a_reject_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |->
      (years_since_1900_o == 11'd0 && day_of_month_o == 5'd0 && day_of_year_o == 9'd0))
    else $error("rejected item carries nonzero fields");

  a_date_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |->
      (day_of_month_o != 5'd0 && month_index_o <= MON_DEC && hour_of_day_o < 5'd24))
    else $error("converted date out of range");

endmodule
